// ----- rtl/dcfl_pkg.sv -----
// Shared types and constants for the descriptor chain free list.
package dcfl_pkg;

	localparam logic [8:0] LINK_END   = 9'd511;
	localparam logic [8:0] EMPTY_SIZE = 9'd128;

	typedef enum logic [1:0] {
		CMD_INIT  = 2'd0,
		CMD_ALLOC = 2'd1,
		CMD_FREE  = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	typedef struct packed {
		logic       flag;
		logic [8:0] link;
	} entry_t;

	typedef struct packed {
		logic       status;
		logic [8:0] head_index;
		logic [8:0] free_count;
	} result_t;

endpackage

// ----- rtl/descriptor_chain_free_list.sv -----
// Descriptor chain free list top level: config register, sequencer, table, output register.
//
// Keeps a linked free list over a DEPTH-entry descriptor table held in one
// single-port-write, registered-read memory. Init builds the list for
// queue_size entries (0 means 128, clamped to DEPTH) at one entry per cycle.
// Allocate of n entries walks the list one entry per cycle, with no walk for
// a count of zero or a refusal. Free of a chain of k entries walks it likewise.
// The walk rate is set by the one table read per cycle. A new word is taken
// as soon as the sequencer is idle, even while the last result still waits in
// the output register. queue_size may be written at any time and takes effect
// at the next init.
module descriptor_chain_free_list import dcfl_pkg::*; #(
	parameter int DEPTH = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [8:0] queue_size,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] command,
	input  logic [8:0] alloc_count,
	input  logic [7:0] chain_head,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       status,
	output logic [8:0] head_index,
	output logic [8:0] free_count
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int TW = (CW > 9) ? CW : 9;

	logic [8:0]    qsize_q;
	logic          out_valid_q;
	result_t       out_q;
	logic          res_valid;
	logic          res_ready;
	result_t       res;
	logic          we;
	logic [AW-1:0] wr_addr;
	entry_t        wr_data;
	logic [AW-1:0] rd_addr;
	entry_t        rd_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qsize_q <= EMPTY_SIZE;
		end else if (cfg_valid) begin
			qsize_q <= queue_size;
		end
	end

	dcfl_table #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_table (
		.clk    (clk),
		.we     (we),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	dcfl_ctrl #(
		.DEPTH(DEPTH),
		.AW   (AW),
		.TW   (TW)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.queue_size (qsize_q),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.command    (command),
		.alloc_count(alloc_count),
		.chain_head (chain_head),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res),
		.we         (we),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data)
	);

	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = out_q.status;
	assign head_index = out_q.head_index;
	assign free_count = out_q.free_count;

endmodule

// ----- rtl/dcfl_table.sv -----
// Descriptor table: one write port, one registered read port, write-first on collision.
module dcfl_table import dcfl_pkg::*; #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] wr_addr,
	input  entry_t        wr_data,
	input  logic [AW-1:0] rd_addr,
	output entry_t        rd_data
);

	entry_t mem [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (we && (wr_addr == rd_addr)) begin
			rd_data <= wr_data;
		end else begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- rtl/dcfl_ctrl.sv -----
// Command sequencer: list init sweep, allocate walk and free walk over the table.
module dcfl_ctrl import dcfl_pkg::*; #(
	parameter int DEPTH = 256,
	parameter int AW    = 8,
	parameter int TW    = 9
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [8:0]    queue_size,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [1:0]    command,
	input  logic [8:0]    alloc_count,
	input  logic [7:0]    chain_head,
	output logic          res_valid,
	input  logic          res_ready,
	output result_t       res,
	output logic          we,
	output logic [AW-1:0] wr_addr,
	output entry_t        wr_data,
	output logic [AW-1:0] rd_addr,
	input  entry_t        rd_data
);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_INIT  = 5'b00010,
		S_AWALK = 5'b00100,
		S_FWALK = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	state_t        state_q, state_d;
	logic [8:0]    idx_q, idx_d;
	logic [8:0]    rem_q, rem_d;
	logic [TW-1:0] cnt_q, cnt_d;
	logic [8:0]    head_q, head_d;
	logic [8:0]    size_q, size_d;
	logic [8:0]    fhead_q, fhead_d;
	logic [TW-1:0] ftot_q, ftot_d;
	result_t       res_q, res_d;

	logic [8:0]    size_sel;
	logic [8:0]    idx_inc;
	logic [8:0]    walk_link;
	logic          idx_inr;
	logic [TW-1:0] cnt_inc;
	logic [TW:0]   ftot_sum;
	logic [TW-1:0] ftot_sat;

	always_comb begin
		size_sel = (queue_size == 9'd0) ? EMPTY_SIZE : queue_size;
		if (32'(size_sel) > DEPTH) begin
			size_sel = 9'(DEPTH);
		end
	end

	assign idx_inc   = idx_q + 9'd1;
	assign idx_inr   = 32'(idx_q) < DEPTH;
	assign walk_link = idx_inr ? rd_data.link : LINK_END;
	assign cnt_inc   = cnt_q + TW'(1);
	assign ftot_sum  = {1'b0, ftot_q} + {1'b0, cnt_inc};
	assign ftot_sat  = (ftot_sum > (TW+1)'(DEPTH)) ? TW'(DEPTH) : ftot_sum[TW-1:0];

	assign in_ready  = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res       = res_q;

	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		rem_d   = rem_q;
		cnt_d   = cnt_q;
		head_d  = head_q;
		size_d  = size_q;
		fhead_d = fhead_q;
		ftot_d  = ftot_q;
		res_d   = res_q;
		we      = 1'b0;
		wr_addr = AW'(idx_q);
		wr_data = '0;
		rd_addr = AW'(idx_q);
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					unique case (cmd_t'(command))
						CMD_INIT: begin
							idx_d   = 9'd0;
							size_d  = size_sel;
							state_d = S_INIT;
						end
						CMD_ALLOC: begin
							if (TW'(alloc_count) > ftot_q) begin
								res_d   = '{1'b1, 9'd0, 9'(ftot_q)};
								state_d = S_DONE;
							end else if (alloc_count == 9'd0) begin
								res_d   = '{1'b0, fhead_q, 9'(ftot_q)};
								state_d = S_DONE;
							end else begin
								head_d  = fhead_q;
								idx_d   = fhead_q;
								rem_d   = alloc_count;
								ftot_d  = ftot_q - TW'(alloc_count);
								rd_addr = AW'(fhead_q);
								state_d = S_AWALK;
							end
						end
						CMD_FREE: begin
							if (32'(chain_head) >= DEPTH) begin
								res_d   = '{1'b1, 9'd0, 9'(ftot_q)};
								state_d = S_DONE;
							end else begin
								head_d  = {1'b0, chain_head};
								idx_d   = {1'b0, chain_head};
								cnt_d   = '0;
								rd_addr = AW'(chain_head);
								state_d = S_FWALK;
							end
						end
						CMD_NOP: begin
							res_d   = '{1'b0, 9'd0, 9'(ftot_q)};
							state_d = S_DONE;
						end
					endcase
				end
			end
			S_INIT: begin
				we      = 1'b1;
				wr_data = '{1'b0, (idx_inc == size_q) ? LINK_END : idx_inc};
				idx_d   = idx_inc;
				if (idx_inc == size_q) begin
					fhead_d = 9'd0;
					ftot_d  = TW'(size_q);
					res_d   = '{1'b0, 9'd0, size_q};
					state_d = S_DONE;
				end
			end
			S_AWALK: begin
				we = idx_inr;
				if (rem_q == 9'd1) begin
					wr_data = '0;
					fhead_d = walk_link;
					res_d   = '{1'b0, head_q, 9'(ftot_q)};
					state_d = S_DONE;
				end else begin
					wr_data = '{1'b1, rd_data.link};
					idx_d   = walk_link;
					rem_d   = rem_q - 9'd1;
					rd_addr = AW'(walk_link);
				end
			end
			S_FWALK: begin
				if (!idx_inr) begin
					res_d   = '{1'b1, 9'd0, 9'(ftot_q)};
					state_d = S_DONE;
				end else if (!rd_data.flag) begin
					we      = 1'b1;
					wr_data = '{1'b0, fhead_q};
					fhead_d = head_q;
					ftot_d  = ftot_sat;
					res_d   = '{1'b0, 9'd0, 9'(ftot_sat)};
					state_d = S_DONE;
				end else if (cnt_inc == TW'(DEPTH)) begin
					res_d   = '{1'b1, 9'd0, 9'(ftot_q)};
					state_d = S_DONE;
				end else begin
					idx_d   = rd_data.link;
					cnt_d   = cnt_inc;
					rd_addr = AW'(rd_data.link);
				end
			end
			S_DONE: begin
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fhead_q <= '0;
			ftot_q  <= '0;
		end else begin
			state_q <= state_d;
			fhead_q <= fhead_d;
			ftot_q  <= ftot_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q  <= idx_d;
		rem_q  <= rem_d;
		cnt_q  <= cnt_d;
		head_q <= head_d;
		size_q <= size_d;
		res_q  <= res_d;
	end

endmodule

// ----- rtl/dcfl_checker.sv -----
// Port-level checks for the descriptor chain free list, bound to the top level.
module dcfl_checker #(
	parameter int DEPTH = 256
) (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic       status,
	input logic [8:0] head_index,
	input logic [8:0] free_count
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(head_index)
			&& $stable(free_count))
		else $error("result word changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("new word taken while previous one still in work");

	a_fail_head_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> head_index == 9'd0)
		else $error("failed result carries a head index");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 32'(free_count) <= DEPTH)
		else $error("free count above table depth");

endmodule

bind descriptor_chain_free_list dcfl_checker #(.DEPTH(DEPTH)) u_dcfl_checker (.*);

// ----- tb/tb.sv -----
// Self-checking testbench for descriptor_chain_free_list with a built-in predictor.
`timescale 1ns / 100ps
module tb;
	import dcfl_pkg::*;

	localparam int DEPTH = 256;
	localparam int PLAN = 0;
	localparam int SHADOW = 1;
	localparam int PRESS_CYCLES = 500;
	localparam int QUIET_LIMIT = 4000;
	localparam int TAIL_CYCLES = 300;
	localparam int PHASE_WORDS = 192;

	typedef struct packed {
		cmd_t       cmd;
		logic [8:0] count;
		logic [7:0] head;
	} word_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [8:0] queue_size = EMPTY_SIZE;
	logic       in_valid = 1'b0;
	logic       in_ready;
	cmd_t       command = CMD_NOP;
	logic [8:0] alloc_count = '0;
	logic [7:0] chain_head = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       status;
	logic [8:0] head_index;
	logic [8:0] free_count;

	descriptor_chain_free_list #(.DEPTH(DEPTH)) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.queue_size (queue_size),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.command    (command),
		.alloc_count(alloc_count),
		.chain_head (chain_head),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.head_index (head_index),
		.free_count (free_count)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// two copies of the table: one steers stimulus ahead of time, one tracks accepted words
	logic [8:0] tbl_link [2][DEPTH];
	logic       tbl_flag [2][DEPTH];
	logic [8:0] list_head [2];
	logic [8:0] list_free [2];
	logic [8:0] size_reg [2];

	word_t       pending_words[$];
	result_t     due_results[$];
	int unsigned live_heads[$];
	int          max_written = 0;
	int          err_cnt = 0;
	bit          src_steady = 1'b0;
	bit          snk_steady = 1'b0;
	int          press_req = 0;
	int          press_seen = 0;
	int          in_gap = 0;
	int          hold_left = 0;
	int          stall_left = 0;
	int          quiet = 0;
	logic        in_taken = 1'b0;

	function automatic result_t free_list_step(int c, cmd_t cmd, logic [8:0] count,
			logic [7:0] head);
		result_t r;
		int sz, idx, nxt, k, tot, i;
		bit found, bad;
		r = '0;
		case (cmd)
			CMD_INIT: begin
				sz = size_reg[c];
				if (sz == 0)
					sz = EMPTY_SIZE;
				if (sz > DEPTH)
					sz = DEPTH;
				for (i = 0; i < sz; i++) begin
					tbl_link[c][i] = (i + 1 == sz) ? LINK_END : 9'(i + 1);
					tbl_flag[c][i] = 1'b0;
				end
				list_head[c] = '0;
				list_free[c] = 9'(sz);
			end
			CMD_ALLOC: begin
				if (list_free[c] < count) begin
					r.status = 1'b1;
				end else begin
					r.head_index = list_head[c];
					idx = list_head[c];
					for (i = 0; i < count; i++) begin
						if (i + 1 == count) begin
							nxt = (idx < DEPTH) ? tbl_link[c][idx] : LINK_END;
							if (idx < DEPTH) begin
								tbl_link[c][idx] = '0;
								tbl_flag[c][idx] = 1'b0;
							end
							list_head[c] = 9'(nxt);
						end else if (idx < DEPTH) begin
							tbl_flag[c][idx] = 1'b1;
							idx = tbl_link[c][idx];
						end else begin
							idx = LINK_END;
						end
					end
					list_free[c] = list_free[c] - count;
				end
			end
			CMD_FREE: begin
				idx = head;
				k = 0;
				found = 1'b0;
				bad = 1'b0;
				while (k < DEPTH && !found && !bad) begin
					if (idx >= DEPTH) begin
						bad = 1'b1;
					end else begin
						k++;
						if (!tbl_flag[c][idx])
							found = 1'b1;
						else
							idx = tbl_link[c][idx];
					end
				end
				if (found) begin
					tbl_link[c][idx] = list_head[c];
					list_head[c] = {1'b0, head};
					tot = list_free[c] + k;
					list_free[c] = (tot > DEPTH) ? 9'(DEPTH) : 9'(tot);
				end else begin
					r.status = 1'b1;
				end
			end
			default: ;
		endcase
		r.free_count = list_free[c];
		return r;
	endfunction

	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 50)
			return 0;
		if (p < 85)
			return $urandom_range(1, 3);
		if (p < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [8:0] pick_count();
		int p;
		p = $urandom_range(0, 99);
		if (p < 55)
			return 9'($urandom_range(1, 3));
		if (p < 75)
			return 9'($urandom_range(4, 10));
		if (p < 85)
			return 9'($urandom_range(0, list_free[PLAN] + 1));
		if (p < 92)
			return '0;
		return 9'($urandom_range(256, 511));
	endfunction

	function automatic logic [8:0] phase_size(int ph);
		case (ph)
			0: return 9'd16;
			1: return 9'd1;
			2: return 9'd2;
			3: return 9'd511;
			4: return 9'd0;
			5: return 9'd300;
			6: return 9'd256;
			default: return 9'($urandom_range(3, 255));
		endcase
	endfunction

	task automatic report_err(string what, int got, int want);
		err_cnt++;
		$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
	endtask

	// runs the word through the planning copy, then queues it for the driver
	task automatic add_word(cmd_t cmd, logic [8:0] count, logic [7:0] head);
		result_t r;
		word_t w;
		r = free_list_step(PLAN, cmd, count, head);
		if (cmd == CMD_INIT) begin
			live_heads.delete();
			if (r.free_count > max_written)
				max_written = r.free_count;
		end
		if (cmd == CMD_ALLOC && !r.status && count != 0 && r.head_index < DEPTH)
			live_heads.push_back(r.head_index);
		w.cmd = cmd;
		w.count = count;
		w.head = head;
		pending_words.push_back(w);
	endtask

	// mostly alloc/free of live chains; some stray frees, re-inits and no-ops
	task automatic rand_word();
		int p, j;
		p = $urandom_range(0, 99);
		if (p >= 44 && p < 82 && live_heads.size() > 0) begin
			j = $urandom_range(0, live_heads.size() - 1);
			add_word(CMD_FREE, 9'($urandom), 8'(live_heads[j]));
			live_heads.delete(j);
		end else if (p >= 82 && p < 88 && max_written > 0) begin
			add_word(CMD_FREE, 9'($urandom), 8'($urandom_range(0, max_written - 1)));
		end else if (p >= 88 && p < 91) begin
			add_word(CMD_INIT, 9'($urandom), 8'($urandom));
		end else if (p >= 91 && p < 95) begin
			add_word(CMD_NOP, 9'($urandom), 8'($urandom));
		end else begin
			add_word(CMD_ALLOC, pick_count(), 8'($urandom));
		end
	endtask

	task automatic wait_idle();
		do
			@(posedge clk);
		while (pending_words.size() != 0 || in_valid || due_results.size() != 0);
	endtask

	task automatic set_queue_size(logic [8:0] val);
		wait_idle();
		@(negedge clk);
		queue_size = val;
		cfg_valid = 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		size_reg[PLAN] = val;
		size_reg[SHADOW] = val;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	always @(negedge clk) begin : feed_words
		word_t w;
		if (arst_n && (!in_valid || in_taken)) begin
			if (in_gap > 0) begin
				in_gap <= in_gap - 1;
				in_valid <= 1'b0;
			end else if (pending_words.size() > 0) begin
				w = pending_words.pop_front();
				command <= w.cmd;
				alloc_count <= w.count;
				chain_head <= w.head;
				in_valid <= 1'b1;
				in_gap <= src_steady ? 0 : pick_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin : take_results
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else if (press_seen != press_req) begin
			press_seen <= press_req;
			hold_left <= PRESS_CYCLES;
			out_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else if (snk_steady || $urandom_range(0, 3) != 0) begin
			out_ready <= 1'b1;
		end else begin
			stall_left <= pick_gap();
			out_ready <= 1'b0;
		end
	end

	always @(posedge clk) begin : check_results
		result_t want;
		in_taken <= in_valid && in_ready;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (due_results.size() == 0) begin
					report_err("result with none pending, head_index", head_index, 0);
				end else begin
					want = due_results.pop_front();
					if (status !== want.status)
						report_err("status", status, want.status);
					if (head_index !== want.head_index)
						report_err("head_index", head_index, want.head_index);
					if (free_count !== want.free_count)
						report_err("free_count", free_count, want.free_count);
				end
			end
			if (in_valid && in_ready)
				due_results.push_back(free_list_step(SHADOW, command, alloc_count, chain_head));
		end
	end

	always @(posedge clk) begin : watchdog
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	initial begin : run
		int c, i, ph;
		for (c = 0; c < 2; c++) begin
			for (i = 0; i < DEPTH; i++) begin
				tbl_link[c][i] = '0;
				tbl_flag[c][i] = 1'b0;
			end
			list_head[c] = '0;
			list_free[c] = '0;
			size_reg[c] = EMPTY_SIZE;
		end
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// nothing built yet: allocs must fail or return the bare head
		add_word(CMD_ALLOC, 9'd1, 8'd0);
		add_word(CMD_ALLOC, 9'd0, 8'd0);
		add_word(CMD_NOP, 9'h1FF, 8'hFF);
		// default size after reset
		add_word(CMD_INIT, 9'd0, 8'd0);
		add_word(CMD_ALLOC, 9'd0, 8'd0);
		add_word(CMD_ALLOC, 9'd1, 8'd0);
		add_word(CMD_ALLOC, 9'd3, 8'd0);
		add_word(CMD_ALLOC, 9'd511, 8'd0);
		add_word(CMD_ALLOC, 9'd256, 8'd0);
		add_word(CMD_FREE, 9'd0, 8'd1);
		add_word(CMD_FREE, 9'd0, 8'd0);
		add_word(CMD_FREE, 9'd0, 8'd1);
		add_word(CMD_NOP, 9'd0, 8'd0);
		// full table: take it all, then over-free
		set_queue_size(9'd256);
		add_word(CMD_INIT, 9'd0, 8'd0);
		add_word(CMD_ALLOC, 9'd256, 8'd0);
		add_word(CMD_ALLOC, 9'd1, 8'd0);
		add_word(CMD_ALLOC, 9'd0, 8'd0);
		add_word(CMD_FREE, 9'd0, 8'd0);
		add_word(CMD_FREE, 9'd0, 8'd0);
		add_word(CMD_FREE, 9'd0, 8'd255);
		// zero means default size; stale chain above the list
		set_queue_size(9'd0);
		add_word(CMD_INIT, 9'd0, 8'd0);
		add_word(CMD_FREE, 9'd0, 8'd200);

		for (ph = 0; ph < 8; ph++) begin
			set_queue_size(phase_size(ph));
			src_steady = (ph == 0) || (ph % 3 == 2);
			snk_steady = (ph % 4 == 3);
			add_word(CMD_INIT, 9'($urandom), 8'($urandom));
			repeat (PHASE_WORDS) rand_word();
			if (ph == 0)
				press_req++;
		end

		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_cnt == 0 && due_results.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
